@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl of the swept box contact block
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SBC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition must never hold
`define SBC_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

@@ rtl/sbc_pkg.sv @@
// shared constants and types of the swept box contact pipeline
// no dependencies
`default_nettype none
package sbc_pkg;
   localparam int VEL_FRAC_BITS_DEF  = 8;
   localparam int TIME_FRAC_BITS_DEF = 16;
   localparam int COORD_W            = 16;
   localparam int SIZE_W             = 15;
   localparam int VEL_W              = 16;
   localparam int DIST_W             = 20;
   localparam int DEN_W              = 16;
   localparam int NORM_W             = 2;

   localparam logic [NORM_W-1:0] NORM_NONE = 2'b00;
   localparam logic [NORM_W-1:0] NORM_POS  = 2'b01;
   localparam logic [NORM_W-1:0] NORM_NEG  = 2'b11;

   typedef struct packed {
      logic miss;
      logic bounded_x;
      logic bounded_y;
      logic neg_x;
      logic neg_y;
   } sbc_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [NORM_W-1:0] normal_x;
      logic [NORM_W-1:0] normal_y;
   } sbc_tag_type;
endpackage
`default_nettype wire

@@ rtl/swept_box_vs_box_contact.sv @@
// top level of the swept box against static box contact test
// depends on sbc_pkg, sbc_slab, sbc_cross, sbc_div and assert_macros.svh
//
// One box pair is taken on every cycle that start is high; busy stays low, so
// the block never refuses a beat. Each pair gives exactly one result beat on
// rsp_strobe, through one stage for the slab bounds, one for the cross products,
// one for the entry and exit decision, one per quotient bit of the contact
// time divider, and the output register. Results come in input order and must
// be taken as shown.
`default_nettype none
`include "assert_macros.svh"
module swept_box_vs_box_contact #(
   parameter int VEL_FRAC_BITS  = sbc_pkg::VEL_FRAC_BITS_DEF,
   parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  req_mover_x,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  req_mover_y,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   req_mover_w,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   req_mover_h,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  req_target_x,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  req_target_y,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   req_target_w,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   req_target_h,
   input  wire logic signed [sbc_pkg::VEL_W-1:0]    req_velocity_x,
   input  wire logic signed [sbc_pkg::VEL_W-1:0]    req_velocity_y,
   output logic                                     rsp_strobe,
   output logic                                     rsp_hit,
   output logic [TIME_FRAC_BITS:0]                  rsp_entry_time,
   output logic signed [sbc_pkg::NORM_W-1:0]        rsp_normal_x,
   output logic signed [sbc_pkg::NORM_W-1:0]        rsp_normal_y
);
   import sbc_pkg::*;

   localparam int NEAR_W = DIST_W + VEL_FRAC_BITS;
   localparam int QB     = TIME_FRAC_BITS + 1;
   localparam logic [QB-1:0] TIME_ONE = QB'(1) << TIME_FRAC_BITS;

   logic                     s1_valid;
   sbc_ctl_type              s1_ctl;
   logic signed [NEAR_W-1:0] s1_near_x, s1_far_x, s1_near_y, s1_far_y;
   logic [DEN_W-1:0]         s1_den_x, s1_den_y;
   logic                     s3_valid;
   sbc_tag_type              s3_tag;
   logic [DEN_W-1:0]         s3_num, s3_den;
   logic                     dv_valid;
   sbc_tag_type              dv_tag;
   logic [QB-1:0]            dv_quot;

   logic                     strobe_ff, hit_ff;
   logic [QB-1:0]            time_ff, time_in;
   logic [NORM_W-1:0]        nx_ff, ny_ff, nx_in, ny_in;

   assign busy = 1'b0;

   sbc_slab #(.VEL_FRAC_BITS(VEL_FRAC_BITS)) u_slab (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .mover_x    (req_mover_x),
      .mover_y    (req_mover_y),
      .mover_w    (req_mover_w),
      .mover_h    (req_mover_h),
      .target_x   (req_target_x),
      .target_y   (req_target_y),
      .target_w   (req_target_w),
      .target_h   (req_target_h),
      .velocity_x (req_velocity_x),
      .velocity_y (req_velocity_y),
      .out_valid  (s1_valid),
      .out_ctl    (s1_ctl),
      .out_near_x (s1_near_x),
      .out_far_x  (s1_far_x),
      .out_den_x  (s1_den_x),
      .out_near_y (s1_near_y),
      .out_far_y  (s1_far_y),
      .out_den_y  (s1_den_y)
   );

   sbc_cross #(.VEL_FRAC_BITS(VEL_FRAC_BITS)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ctl    (s1_ctl),
      .in_near_x (s1_near_x),
      .in_far_x  (s1_far_x),
      .in_den_x  (s1_den_x),
      .in_near_y (s1_near_y),
      .in_far_y  (s1_far_y),
      .in_den_y  (s1_den_y),
      .out_valid (s3_valid),
      .out_tag   (s3_tag),
      .out_num   (s3_num),
      .out_den   (s3_den)
   );

   sbc_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_tag    (s3_tag),
      .in_num    (s3_num),
      .in_den    (s3_den),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quot  (dv_quot)
   );

   // a miss reports zero time and no normal
   always_comb begin
      time_in = dv_tag.hit ? dv_quot : '0;
      nx_in   = dv_tag.hit ? dv_tag.normal_x : NORM_NONE;
      ny_in   = dv_tag.hit ? dv_tag.normal_y : NORM_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= dv_tag.hit;
      time_ff <= time_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_entry_time = time_ff;
   assign rsp_normal_x   = nx_ff;
   assign rsp_normal_y   = ny_ff;

   `SBC_ASSERT_IMP(a_miss_clean, rsp_strobe && !rsp_hit,
      rsp_entry_time == '0 && rsp_normal_x == NORM_NONE && rsp_normal_y == NORM_NONE,
      "miss beat carries time or normal")
   `SBC_ASSERT_IMP(a_time_range, rsp_strobe && rsp_hit, rsp_entry_time <= TIME_ONE,
      "contact time beyond one frame")
   `SBC_ASSERT_NEVER(a_one_face,
      rsp_strobe && rsp_normal_x != NORM_NONE && rsp_normal_y != NORM_NONE,
      "normal on both axes")
endmodule
`default_nettype wire

@@ rtl/sbc_slab.sv @@
// first stage: grown box distances and per axis slab bounds
// depends on sbc_pkg
`default_nettype none
module sbc_slab #(
   parameter int VEL_FRAC_BITS = sbc_pkg::VEL_FRAC_BITS_DEF,
   localparam int NEAR_W = sbc_pkg::DIST_W + VEL_FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  mover_x,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  mover_y,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   mover_w,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   mover_h,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  target_x,
   input  wire logic signed [sbc_pkg::COORD_W-1:0]  target_y,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   target_w,
   input  wire logic        [sbc_pkg::SIZE_W-1:0]   target_h,
   input  wire logic signed [sbc_pkg::VEL_W-1:0]    velocity_x,
   input  wire logic signed [sbc_pkg::VEL_W-1:0]    velocity_y,
   output logic                                     out_valid,
   output sbc_pkg::sbc_ctl_type                     out_ctl,
   output logic signed [NEAR_W-1:0]                 out_near_x,
   output logic signed [NEAR_W-1:0]                 out_far_x,
   output logic        [sbc_pkg::DEN_W-1:0]         out_den_x,
   output logic signed [NEAR_W-1:0]                 out_near_y,
   output logic signed [NEAR_W-1:0]                 out_far_y,
   output logic        [sbc_pkg::DEN_W-1:0]         out_den_y
);
   import sbc_pkg::*;

   logic signed [DIST_W-1:0] d0x, d1x, d0y, d1y;
   logic                     zx, zy, okx, oky;
   logic                     valid_ff;
   sbc_ctl_type              ctl_ff, ctl_in;
   logic signed [NEAR_W-1:0] near_x_ff, far_x_ff, near_y_ff, far_y_ff;
   logic signed [NEAR_W-1:0] near_x_in, far_x_in, near_y_in, far_y_in;
   logic [DEN_W-1:0]         den_x_ff, den_y_ff, den_x_in, den_y_in;

   always_comb begin
      d0x = DIST_W'(target_x) - DIST_W'(mover_w >> 1) - DIST_W'(mover_x)
            - DIST_W'(mover_w >> 1);
      d1x = d0x + DIST_W'(target_w) + DIST_W'(mover_w);
      d0y = DIST_W'(target_y) - DIST_W'(mover_h >> 1) - DIST_W'(mover_y)
            - DIST_W'(mover_h >> 1);
      d1y = d0y + DIST_W'(target_h) + DIST_W'(mover_h);
      zx  = (velocity_x == '0);
      zy  = (velocity_y == '0);
      okx = !zx || (d0x <= 0 && d1x >= 0);
      oky = !zy || (d0y <= 0 && d1y >= 0);

      // moving toward negative: swap and negate the edges
      if (velocity_x[VEL_W-1]) begin
         near_x_in = NEAR_W'(-d1x) <<< VEL_FRAC_BITS;
         far_x_in  = NEAR_W'(-d0x) <<< VEL_FRAC_BITS;
         den_x_in  = DEN_W'(-velocity_x);
      end else begin
         near_x_in = NEAR_W'(d0x) <<< VEL_FRAC_BITS;
         far_x_in  = NEAR_W'(d1x) <<< VEL_FRAC_BITS;
         den_x_in  = DEN_W'(velocity_x);
      end
      if (velocity_y[VEL_W-1]) begin
         near_y_in = NEAR_W'(-d1y) <<< VEL_FRAC_BITS;
         far_y_in  = NEAR_W'(-d0y) <<< VEL_FRAC_BITS;
         den_y_in  = DEN_W'(-velocity_y);
      end else begin
         near_y_in = NEAR_W'(d0y) <<< VEL_FRAC_BITS;
         far_y_in  = NEAR_W'(d1y) <<< VEL_FRAC_BITS;
         den_y_in  = DEN_W'(velocity_y);
      end

      ctl_in.miss      = (zx && zy) || !okx || !oky;
      ctl_in.bounded_x = !zx;
      ctl_in.bounded_y = !zy;
      ctl_in.neg_x     = velocity_x[VEL_W-1];
      ctl_in.neg_y     = velocity_y[VEL_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff    <= ctl_in;
      near_x_ff <= near_x_in;
      far_x_ff  <= far_x_in;
      den_x_ff  <= den_x_in;
      near_y_ff <= near_y_in;
      far_y_ff  <= far_y_in;
      den_y_ff  <= den_y_in;
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_near_x = near_x_ff;
   assign out_far_x  = far_x_ff;
   assign out_den_x  = den_x_ff;
   assign out_near_y = near_y_ff;
   assign out_far_y  = far_y_ff;
   assign out_den_y  = den_y_ff;
endmodule
`default_nettype wire

@@ rtl/sbc_cross.sv @@
// second and third stages: cross products of slab times, then
// entry/exit selection, face normal and hit decision; depends on sbc_pkg
`default_nettype none
module sbc_cross #(
   parameter int VEL_FRAC_BITS = sbc_pkg::VEL_FRAC_BITS_DEF,
   localparam int NEAR_W = sbc_pkg::DIST_W + VEL_FRAC_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire sbc_pkg::sbc_ctl_type         in_ctl,
   input  wire logic signed [NEAR_W-1:0]     in_near_x,
   input  wire logic signed [NEAR_W-1:0]     in_far_x,
   input  wire logic [sbc_pkg::DEN_W-1:0]    in_den_x,
   input  wire logic signed [NEAR_W-1:0]     in_near_y,
   input  wire logic signed [NEAR_W-1:0]     in_far_y,
   input  wire logic [sbc_pkg::DEN_W-1:0]    in_den_y,
   output logic                              out_valid,
   output sbc_pkg::sbc_tag_type              out_tag,
   output logic [sbc_pkg::DEN_W-1:0]         out_num,
   output logic [sbc_pkg::DEN_W-1:0]         out_den
);
   import sbc_pkg::*;

   localparam int PROD_W = NEAR_W + DEN_W + 1;

   // product stage
   logic                     p_valid_ff;
   sbc_ctl_type              p_ctl_ff;
   logic signed [NEAR_W-1:0] p_near_x_ff, p_far_x_ff, p_near_y_ff, p_far_y_ff;
   logic [DEN_W-1:0]         p_den_x_ff, p_den_y_ff;
   logic signed [PROD_W-1:0] fy_dx_ff, nx_dy_ff, fx_dy_ff, ny_dx_ff;
   logic signed [PROD_W-1:0] fy_dx_in, nx_dy_in, fx_dy_in, ny_dx_in;

   // decision stage
   logic                     d_valid_ff;
   sbc_tag_type              d_tag_ff, d_tag_in;
   logic [DEN_W-1:0]         d_num_ff, d_den_ff;
   logic signed [NEAR_W-1:0] sel_near, sel_far;
   logic [DEN_W-1:0]         sel_den;
   logic                     ok;

   always_comb begin
      fy_dx_in = in_far_y  * $signed({1'b0, in_den_x});
      nx_dy_in = in_near_x * $signed({1'b0, in_den_y});
      fx_dy_in = in_far_x  * $signed({1'b0, in_den_y});
      ny_dx_in = in_near_y * $signed({1'b0, in_den_x});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         d_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ctl_ff    <= in_ctl;
      p_near_x_ff <= in_near_x;
      p_far_x_ff  <= in_far_x;
      p_den_x_ff  <= in_den_x;
      p_near_y_ff <= in_near_y;
      p_far_y_ff  <= in_far_y;
      p_den_y_ff  <= in_den_y;
      fy_dx_ff    <= fy_dx_in;
      nx_dy_ff    <= nx_dy_in;
      fx_dy_ff    <= fx_dy_in;
      ny_dx_ff    <= ny_dx_in;
   end

   always_comb begin
      sel_near          = p_near_x_ff;
      sel_far           = p_far_x_ff;
      sel_den           = p_den_x_ff;
      d_tag_in.normal_x = NORM_NONE;
      d_tag_in.normal_y = NORM_NONE;
      ok                = !p_ctl_ff.miss;
      if (p_ctl_ff.bounded_x && p_ctl_ff.bounded_y) begin
         // slabs disjoint in time
         if (fy_dx_ff < nx_dy_ff || fx_dy_ff < ny_dx_ff) begin
            ok = 1'b0;
         end
         if (ny_dx_ff < nx_dy_ff) begin
            d_tag_in.normal_x = p_ctl_ff.neg_x ? NORM_POS : NORM_NEG;
         end else if (nx_dy_ff < ny_dx_ff) begin
            sel_near          = p_near_y_ff;
            sel_den           = p_den_y_ff;
            d_tag_in.normal_y = p_ctl_ff.neg_y ? NORM_POS : NORM_NEG;
         end
         if (!(fx_dy_ff < fy_dx_ff)) begin
            sel_far = p_far_y_ff;
         end
      end else if (p_ctl_ff.bounded_x) begin
         d_tag_in.normal_x = p_ctl_ff.neg_x ? NORM_POS : NORM_NEG;
      end else begin
         sel_near          = p_near_y_ff;
         sel_far           = p_far_y_ff;
         sel_den           = p_den_y_ff;
         d_tag_in.normal_y = p_ctl_ff.neg_y ? NORM_POS : NORM_NEG;
      end
      d_tag_in.hit = ok && !sel_far[NEAR_W-1] && !sel_near[NEAR_W-1]
                     && (sel_near <= $signed(NEAR_W'(sel_den)));
   end

   always_ff @(posedge clock) begin
      d_tag_ff <= d_tag_in;
      d_num_ff <= sel_near[DEN_W-1:0];
      d_den_ff <= sel_den;
   end

   assign out_valid = d_valid_ff;
   assign out_tag   = d_tag_ff;
   assign out_num   = d_num_ff;
   assign out_den   = d_den_ff;
endmodule
`default_nettype wire

@@ rtl/sbc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, for the
// contact time; carries the hit tag alongside; depends on sbc_pkg
`default_nettype none
module sbc_div #(
   parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF,
   localparam int QB = TIME_FRAC_BITS + 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire sbc_pkg::sbc_tag_type       in_tag,
   input  wire logic [sbc_pkg::DEN_W-1:0]  in_num,
   input  wire logic [sbc_pkg::DEN_W-1:0]  in_den,
   output logic                            out_valid,
   output sbc_pkg::sbc_tag_type            out_tag,
   output logic [QB-1:0]                   out_quot
);
   import sbc_pkg::*;

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic             valid_ff;
      sbc_tag_type      tag_ff;
      logic [DEN_W:0]   rem_ff;
      logic [DEN_W-1:0] den_ff;
      logic [QB-1:0]    quot_ff;
      logic             prev_valid;
      sbc_tag_type      prev_tag;
      logic [DEN_W:0]   prev_rem, trial, rem_in;
      logic [DEN_W-1:0] prev_den;
      logic [QB-1:0]    prev_quot;
      logic             ge;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_tag   = in_tag;
         assign prev_rem   = {1'b0, in_num};
         assign prev_den   = in_den;
         assign prev_quot  = '0;
         assign trial      = prev_rem;
      end else begin : g_next
         assign prev_valid = g_stage[k-1].valid_ff;
         assign prev_tag   = g_stage[k-1].tag_ff;
         assign prev_rem   = g_stage[k-1].rem_ff;
         assign prev_den   = g_stage[k-1].den_ff;
         assign prev_quot  = g_stage[k-1].quot_ff;
         assign trial      = {prev_rem[DEN_W-1:0], 1'b0};
      end

      assign ge     = (trial >= {1'b0, prev_den});
      assign rem_in = ge ? (trial - {1'b0, prev_den}) : trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         tag_ff  <= prev_tag;
         rem_ff  <= rem_in;
         den_ff  <= prev_den;
         quot_ff <= {prev_quot[QB-2:0], ge};
      end
   end

   assign out_valid = g_stage[QB-1].valid_ff;
   assign out_tag   = g_stage[QB-1].tag_ff;
   assign out_quot  = g_stage[QB-1].quot_ff;
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the swept box against static box contact test
// depends on sbc_pkg and the swept_box_vs_box_contact rtl; predicts every beat itself
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
   logic signed [15:0] mover_x, mover_y;
   logic [14:0]        mover_w, mover_h;
   logic signed [15:0] target_x, target_y;
   logic [14:0]        target_w, target_h;
   logic signed [15:0] velocity_x, velocity_y;
} box_pair_type;

typedef struct {
   logic        hit;
   logic [16:0] entry_time;
   logic [1:0]  normal_x, normal_y;
} contact_type;

class contact_scoreboard;
   contact_type pending[$];
   int mismatches = 0;
   int pairs = 0;
   int hits = 0;

   // axis interval; returns 0 when the axis can never be entered
   static function bit axis_span(longint d0, longint d1, longint v, output bit bounded,
                                 output longint near_n, output longint far_n,
                                 output longint den);
      bounded = (v != 0);
      near_n = 0; far_n = 0; den = 1;
      if (v == 0) return (d0 <= 0 && d1 >= 0);
      if (v > 0) begin
         near_n = d0 * 256; far_n = d1 * 256; den = v;
      end else begin
         near_n = -d1 * 256; far_n = -d0 * 256; den = -v;
      end
      return 1'b1;
   endfunction

   static function contact_type predict_contact(box_pair_type p);
      contact_type c;
      longint mw, mh, vx, vy, d0x, d0y;
      longint xn, xf, xd, yn, yf, yd, nn, nd, fn;
      bit bx, by, ok;
      c.hit = 1'b0; c.entry_time = '0;
      c.normal_x = sbc_pkg::NORM_NONE; c.normal_y = sbc_pkg::NORM_NONE;
      vx = p.velocity_x; vy = p.velocity_y;
      mw = p.mover_w; mh = p.mover_h;
      if (vx == 0 && vy == 0) return c;
      d0x = (longint'(p.target_x) - (mw >> 1)) - (longint'(p.mover_x) + (mw >> 1));
      d0y = (longint'(p.target_y) - (mh >> 1)) - (longint'(p.mover_y) + (mh >> 1));
      ok = axis_span(d0x, d0x + longint'(p.target_w) + mw, vx, bx, xn, xf, xd);
      if (!ok) return c;
      ok = axis_span(d0y, d0y + longint'(p.target_h) + mh, vy, by, yn, yf, yd);
      if (!ok) return c;
      if (bx && by) begin
         if (yf * xd < xn * yd || xf * yd < yn * xd) return c;
         if (yn * xd < xn * yd) begin
            nn = xn; nd = xd;
            c.normal_x = vx < 0 ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
         end else if (xn * yd < yn * xd) begin
            nn = yn; nd = yd;
            c.normal_y = vy < 0 ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
         end else begin
            nn = xn; nd = xd;
         end
         fn = (xf * yd < yf * xd) ? xf : yf;
      end else if (bx) begin
         nn = xn; nd = xd; fn = xf;
         c.normal_x = vx < 0 ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
      end else begin
         nn = yn; nd = yd; fn = yf;
         c.normal_y = vy < 0 ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
      end
      if (fn < 0 || nn < 0 || nn > nd) begin
         c.normal_x = sbc_pkg::NORM_NONE; c.normal_y = sbc_pkg::NORM_NONE;
         return c;
      end
      c.hit = 1'b1;
      c.entry_time = 17'((nn << 16) / nd);
      return c;
   endfunction

   function void note_pair(box_pair_type p);
      contact_type c;
      c = predict_contact(p);
      pairs++;
      if (c.hit) hits++;
      pending = {pending, c};
   endfunction

   function void check_contact(contact_type got);
      contact_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
         return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit || got.entry_time !== want.entry_time ||
          got.normal_x !== want.normal_x || got.normal_y !== want.normal_y) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: want hit %0d t %0d n %0d,%0d got hit %0d t %0d n %0d,%0d",
                     want.hit, want.entry_time, $signed(want.normal_x),
                     $signed(want.normal_y), got.hit, got.entry_time,
                     $signed(got.normal_x), $signed(got.normal_y));
      end
   endfunction
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   box_pair_type pair = '{default: '0};
   logic rsp_strobe, rsp_hit;
   logic [16:0] rsp_entry_time;
   logic signed [1:0] rsp_normal_x, rsp_normal_y;
   contact_scoreboard board = new();
   int cycles = 0;

   swept_box_vs_box_contact dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mover_x(pair.mover_x), .req_mover_y(pair.mover_y),
      .req_mover_w(pair.mover_w), .req_mover_h(pair.mover_h),
      .req_target_x(pair.target_x), .req_target_y(pair.target_y),
      .req_target_w(pair.target_w), .req_target_h(pair.target_h),
      .req_velocity_x(pair.velocity_x), .req_velocity_y(pair.velocity_y),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_entry_time(rsp_entry_time),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      contact_type got;
      if (!reset && rsp_strobe) begin
         got.hit = rsp_hit; got.entry_time = rsp_entry_time;
         got.normal_x = rsp_normal_x; got.normal_y = rsp_normal_y;
         board.check_contact(got);
      end
   end

   // one beat; start stays high across back to back beats
   task automatic send_pair(box_pair_type p, int gap);
      pair <= p;
      start <= 1;
      do @(posedge clock); while (busy);
      board.note_pair(p);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic box_pair_type make_pair(int mx, int my, int mw, int mh, int tx, int ty,
                                              int tw, int th, int vx, int vy);
      box_pair_type p;
      p.mover_x = 16'(mx); p.mover_y = 16'(my); p.mover_w = 15'(mw); p.mover_h = 15'(mh);
      p.target_x = 16'(tx); p.target_y = 16'(ty); p.target_w = 15'(tw);
      p.target_h = 15'(th); p.velocity_x = 16'(vx); p.velocity_y = 16'(vy);
      return p;
   endfunction

   function automatic int near_int(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic box_pair_type random_pair();
      box_pair_type p;
      int sel, tx, ty;
      sel = int'($urandom_range(0, 9));
      if (sel < 3) begin
         p.mover_x = 16'($urandom); p.mover_y = 16'($urandom);
         p.mover_w = 15'($urandom); p.mover_h = 15'($urandom);
         p.target_x = 16'($urandom); p.target_y = 16'($urandom);
         p.target_w = 15'($urandom); p.target_h = 15'($urandom);
         p.velocity_x = 16'($urandom); p.velocity_y = 16'($urandom);
         return p;
      end
      // nearby boxes so that most pairs reach the slab comparisons
      tx = near_int(30000); ty = near_int(30000);
      p.target_x = 16'(tx); p.target_y = 16'(ty);
      p.target_w = 15'($urandom_range(0, 64)); p.target_h = 15'($urandom_range(0, 64));
      p.mover_w = 15'($urandom_range(0, 64)); p.mover_h = 15'($urandom_range(0, 64));
      if (sel == 9) begin
         p.target_w = 15'($urandom); p.mover_h = 15'($urandom);
      end
      p.mover_x = 16'(tx + near_int(160)); p.mover_y = 16'(ty + near_int(160));
      p.velocity_x = 16'(near_int(32767)); p.velocity_y = 16'(near_int(32767));
      if ($urandom_range(0, 7) == 0) p.velocity_x = '0;
      else if ($urandom_range(0, 7) == 0) p.velocity_y = '0;
      return p;
   endfunction

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7));
   endfunction

   initial begin
      box_pair_type directed[$];
      int burst;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed = {directed, make_pair(0, 0, 10, 10, 50, 0, 10, 10, 0, 0)};          // still
      directed = {directed, make_pair(0, 0, 10, 10, 50, 0, 10, 10, 25600, 0)};      // from left
      directed = {directed, make_pair(100, 0, 10, 10, 50, 0, 10, 10, -25600, 0)};   // from right
      directed = {directed, make_pair(0, 0, 10, 10, 0, 50, 10, 10, 0, 25600)};      // from above
      directed = {directed, make_pair(0, 100, 10, 10, 0, 50, 10, 10, 0, -25600)};   // from below
      directed = {directed, make_pair(0, 30, 10, 10, 50, 0, 10, 10, 25600, 0)};     // outside
      directed = {directed, make_pair(0, 10, 10, 10, 50, 0, 10, 10, 25600, 0)};     // edge
      directed = {directed, make_pair(0, 0, 10, 10, 50, 50, 10, 10, 12800, 12800)}; // corner
      directed = {directed, make_pair(0, 0, 10, 10, 50, 80, 10, 10, 12800, 12800)}; // disjoint
      directed = {directed, make_pair(100, 0, 10, 10, 50, 0, 10, 10, 25600, 0)};    // behind
      directed = {directed, make_pair(0, 0, 10, 10, 500, 0, 10, 10, 25600, 0)};     // too far
      directed = {directed, make_pair(0, 0, 10, 10, 5, 0, 10, 10, 256, 0)};         // overlap
      directed = {directed, make_pair(0, 0, 0, 0, 40, 0, 0, 0, 10240, 0)};          // zero sizes
      directed = {directed, make_pair(0, 0, 0, 0, 40, 0, 0, 0, 10240, 1)};
      directed = {directed, make_pair(-32768, -32768, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767)};
      directed = {directed, make_pair(32767, 32767, 32767, 32767, -32768, -32768,
                                      32767, 32767, -32768, -32768)};
      directed = {directed, make_pair(-32768, 0, 1, 1, 32767, 0, 0, 0, 32767, 0)};
      directed = {directed, make_pair(0, 0, 32767, 0, 0, 0, 0, 32767, -1, -32768)};
      directed = {directed, make_pair(0, 0, 10, 10, 50, 0, 10, 10, 1, 0)};          // tiny speed
      directed = {directed, make_pair(0, 0, 11, 11, 50, 3, 7, 9, 10241, -3)};       // odd halves
      foreach (directed[i]) send_pair(directed[i], draw_gap());

      burst = 0;
      for (int n = 0; n < 1450; n++) begin
         if (burst == 0 && $urandom_range(0, 15) == 0) burst = int'($urandom_range(10, 40));
         if (burst > 0) begin
            burst--;
            send_pair(random_pair(), 0);
         end else begin
            send_pair(random_pair(), int'($urandom_range(0, 7)));
         end
      end
      start <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("sent %0d box pairs, %0d predicted contacts, %0d mismatches",
               board.pairs, board.hits, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/sbc_pkg.sv
rtl/sbc_slab.sv
rtl/sbc_cross.sv
rtl/sbc_div.sv
rtl/swept_box_vs_box_contact.sv
test/testbench.sv
